/* src/uest_pkg.sv */
// Package: shared constants, types and controller/datapath command structs.
package uest_pkg;

  localparam int NumOps      = 256;
  localparam int IdxW        = $clog2(NumOps);
  localparam int LogFracBits = 16;
  localparam int FracSteps   = LogFracBits + 1;
  localparam int StepW       = $clog2(FracSteps + 1);
  localparam int ExpW        = 6;
  localparam int BitsW       = 23;
  localparam int TotW        = 48;
  localparam int CntW        = 32;
  localparam int RecW        = BitsW + TotW + CntW;

  localparam logic [BitsW-1:0] ThreshReset = BitsW'(327680);
  localparam logic [63:0]      Sign64      = 64'h8000_0000_0000_0000;
  localparam logic [62:0]      InfMag      = 63'h7FF0_0000_0000_0000;

  typedef struct packed {
    logic accept;
    logic load;
    logic norm;
    logic mul;
    logic acc;
    logic fin;
    logic upd;
  } cmd_t;

  typedef struct packed {
    logic norm_done;
    logic last_step;
    logic out_free;
  } status_t;

endpackage

/* src/uest_if.sv */
// Interfaces: input item, result item and configuration write channels.
interface uest_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] reference_bits;
  logic [63:0] computed_bits;
  logic [7:0]  op_index;
  modport source (output valid, reference_bits, computed_bits, op_index, input ready);
  modport sink   (input valid, reference_bits, computed_bits, op_index, output ready);
endinterface

interface uest_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] ulp_distance;
  logic [22:0] bits_error;
  logic        is_new_max;
  logic        start_tracking;
  logic [22:0] max_error_now;
  logic [47:0] total_error_now;
  logic [31:0] call_count_now;
  modport source (output valid, ulp_distance, bits_error, is_new_max, start_tracking,
                  max_error_now, total_error_now, call_count_now, input ready);
  modport sink   (input valid, ulp_distance, bits_error, is_new_max, start_tracking,
                  max_error_now, total_error_now, call_count_now, output ready);
endinterface

interface uest_cfg_if;
  logic        valid;
  logic        ready;
  logic [22:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

/* src/uest_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module uest_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/uest_ctrl.sv */
// Controller: sequences accept, normalize, squaring steps, rounding and update.
module uest_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  uest_pkg::status_t status_i,
  output uest_pkg::cmd_t    cmd_o
);
  import uest_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StLoad = 3'd1;
  localparam logic [2:0] StNorm = 3'd2;
  localparam logic [2:0] StMul  = 3'd3;
  localparam logic [2:0] StAcc  = 3'd4;
  localparam logic [2:0] StFin  = 3'd5;
  localparam logic [2:0] StUpd  = 3'd6;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = StLoad;
        end
      end
      StLoad: begin
        cmd_o.load = 1'b1;
        state_d    = StNorm;
      end
      StNorm: begin
        if (status_i.norm_done) begin
          state_d = StMul;
        end else begin
          cmd_o.norm = 1'b1;
        end
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        state_d   = StAcc;
      end
      StAcc: begin
        cmd_o.acc = 1'b1;
        state_d   = status_i.last_step ? StFin : StMul;
      end
      StFin: begin
        cmd_o.fin = 1'b1;
        state_d   = StUpd;
      end
      StUpd: begin
        if (status_i.out_free) begin
          cmd_o.upd = 1'b1;
          state_d   = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* src/uest_dp.sv */
// Datapath: ULP distance, iterative log2, statistics record update, output register.
module uest_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  uest_pkg::cmd_t    cmd_i,
  output uest_pkg::status_t status_o,
  input  logic [63:0]       reference_bits_i,
  input  logic [63:0]       computed_bits_i,
  input  logic [7:0]        op_index_i,
  input  logic              cfg_valid_i,
  input  logic [22:0]       cfg_data_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [63:0]       ulp_distance_o,
  output logic [22:0]       bits_error_o,
  output logic              is_new_max_o,
  output logic              start_tracking_o,
  output logic [22:0]       max_error_now_o,
  output logic [47:0]       total_error_now_o,
  output logic [31:0]       call_count_now_o
);
  import uest_pkg::*;

  logic [BitsW-1:0]     thr_q;
  logic [63:0]          ulps_q;
  logic [IdxW-1:0]      idx_q;
  logic [63:0]          m_q;
  logic [ExpW-1:0]      e_q;
  logic [FracSteps-1:0] frac_q;
  logic [StepW-1:0]     step_q;
  logic [63:0]          p_hh_q, p_hl_q, p_ll_q;
  logic [BitsW-1:0]     bits_q;
  logic [NumOps-1:0]    valid_q;
  logic [RecW-1:0]      rd_data;

  logic                 out_valid_q;
  logic [63:0]          o_ulps_q;
  logic [BitsW-1:0]     o_bits_q, o_max_q;
  logic                 o_newmax_q, o_start_q;
  logic [TotW-1:0]      o_tot_q;
  logic [CntW-1:0]      o_cnt_q;

  // ULP distance of the incoming pair
  logic        nan_r, nan_c;
  logic [63:0] key_r, key_c, ulps_d;
  always_comb begin
    nan_r = reference_bits_i[62:0] > InfMag;
    nan_c = computed_bits_i[62:0] > InfMag;
    key_r = reference_bits_i[63] ? Sign64 - {1'b0, reference_bits_i[62:0]}
                                 : Sign64 + {1'b0, reference_bits_i[62:0]};
    key_c = computed_bits_i[63] ? Sign64 - {1'b0, computed_bits_i[62:0]}
                                : Sign64 + {1'b0, computed_bits_i[62:0]};
    if (nan_r && nan_c) begin
      ulps_d = '0;
    end else if (nan_r || nan_c) begin
      ulps_d = Sign64;
    end else if (key_r >= key_c) begin
      ulps_d = key_r - key_c;
    end else begin
      ulps_d = key_c - key_r;
    end
  end

  // squaring step combine
  logic [127:0] sq;
  assign sq = {p_hh_q, p_ll_q} + {31'b0, p_hl_q, 33'b0};

  logic [BitsW:0] round_sum;
  assign round_sum = {1'b0, e_q, frac_q} + (BitsW + 1)'(1);

  // record update
  logic [BitsW-1:0] old_max, new_max;
  logic [TotW-1:0]  old_tot, new_tot;
  logic [CntW-1:0]  old_cnt, new_cnt;
  logic [TotW:0]    tot_sum;
  logic             newmax, start;
  always_comb begin
    if (valid_q[idx_q]) begin
      {old_max, old_tot, old_cnt} = rd_data;
    end else begin
      {old_max, old_tot, old_cnt} = '0;
    end
    newmax  = bits_q > old_max;
    start   = newmax && (old_max < thr_q) && (bits_q > thr_q);
    new_max = newmax ? bits_q : old_max;
    tot_sum = {1'b0, old_tot} + (TotW + 1)'(bits_q);
    new_tot = tot_sum[TotW] ? {TotW{1'b1}} : tot_sum[TotW-1:0];
    new_cnt = (old_cnt == {CntW{1'b1}}) ? old_cnt : old_cnt + CntW'(1);
  end

  uest_ram #(.Width(RecW), .Depth(NumOps)) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.upd),
    .waddr_i (idx_q),
    .wdata_i ({new_max, new_tot, new_cnt}),
    .re_i    (cmd_i.accept),
    .raddr_i (op_index_i[IdxW-1:0]),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      ulps_q <= ulps_d;
      idx_q  <= op_index_i[IdxW-1:0];
    end
    if (cmd_i.load) begin
      m_q    <= ulps_q + 64'd1;
      e_q    <= ExpW'(63);
      step_q <= '0;
      frac_q <= '0;
    end else if (cmd_i.norm) begin
      if (m_q[63:56] == 8'd0) begin
        m_q <= m_q << 8;
        e_q <= e_q - ExpW'(8);
      end else begin
        m_q <= m_q << 1;
        e_q <= e_q - ExpW'(1);
      end
    end else if (cmd_i.acc) begin
      m_q    <= sq[127] ? sq[127:64] : sq[126:63];
      frac_q <= {frac_q[FracSteps-2:0], sq[127]};
      step_q <= step_q + StepW'(1);
    end
    if (cmd_i.mul) begin
      p_hh_q <= m_q[63:32] * m_q[63:32];
      p_hl_q <= m_q[63:32] * m_q[31:0];
      p_ll_q <= m_q[31:0] * m_q[31:0];
    end
    if (cmd_i.fin) begin
      bits_q <= round_sum[BitsW:1];
    end
    if (cmd_i.upd) begin
      o_ulps_q   <= ulps_q;
      o_bits_q   <= bits_q;
      o_newmax_q <= newmax;
      o_start_q  <= start;
      o_max_q    <= new_max;
      o_tot_q    <= new_tot;
      o_cnt_q    <= new_cnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q       <= ThreshReset;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        thr_q <= cfg_data_i;
      end
      if (cmd_i.upd) begin
        valid_q[idx_q] <= 1'b1;
        out_valid_q    <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.norm_done = m_q[63];
  assign status_o.last_step = step_q == StepW'(FracSteps - 1);
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o       = out_valid_q;
  assign ulp_distance_o    = o_ulps_q;
  assign bits_error_o      = o_bits_q;
  assign is_new_max_o      = o_newmax_q;
  assign start_tracking_o  = o_start_q;
  assign max_error_now_o   = o_max_q;
  assign total_error_now_o = o_tot_q;
  assign call_count_now_o  = o_cnt_q;

endmodule

/* src/ulp_error_statistics_table.sv */
// Top level: ULP error statistics table (controller plus datapath).
// Takes one transaction of two double bit patterns and an operation index,
// returns the ULP distance (-0 equals +0, both NaN gives 0, one NaN gives
// 2^63), the bits error log2(ulps+1) in Q7.16 rounded to nearest, and the
// updated per-operation record: maximum, saturating total (48 bits),
// saturating count (32 bits), plus new-max and threshold-crossing flags.
// One item is in flight at a time; the next is accepted after the record
// update of the last. The log2 unit does most of the work: a normalize
// loop (eight bits, then one bit at a time) and 17 squaring steps, each a
// multiply state for three 32x32 partial products and an accumulate state
// for the 128-bit combine. The record lives in a 256-entry RAM read at
// accept and written at the end; per-entry valid bits make reset records
// read as zero with no clearing pass. The output register lets the next
// item be accepted while a result waits. The threshold, on the always-ready
// cfg channel, must be written only while the block is idle (not enforced).
module ulp_error_statistics_table (
  input logic clk_i,
  input logic rst_ni,
  uest_in_if.sink    in_i,
  uest_out_if.source out_o,
  uest_cfg_if.sink   cfg_i
);
  import uest_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  uest_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  uest_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .reference_bits_i  (in_i.reference_bits),
    .computed_bits_i   (in_i.computed_bits),
    .op_index_i        (in_i.op_index),
    .cfg_valid_i       (cfg_i.valid),
    .cfg_data_i        (cfg_i.data),
    .out_ready_i       (out_o.ready),
    .out_valid_o       (out_o.valid),
    .ulp_distance_o    (out_o.ulp_distance),
    .bits_error_o      (out_o.bits_error),
    .is_new_max_o      (out_o.is_new_max),
    .start_tracking_o  (out_o.start_tracking),
    .max_error_now_o   (out_o.max_error_now),
    .total_error_now_o (out_o.total_error_now),
    .call_count_now_o  (out_o.call_count_now)
  );

  assign in_i.ready  = in_ready;
  assign cfg_i.ready = 1'b1;

  a_start_needs_max : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.start_tracking |-> out_o.is_new_max)
    else $error("start_tracking without new max");

  a_newmax_value : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.is_new_max |-> out_o.max_error_now == out_o.bits_error)
    else $error("new max not stored");

  a_count_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.call_count_now != 32'd0)
    else $error("zero call count on result");

  a_max_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.max_error_now >= out_o.bits_error)
    else $error("max below current error");

endmodule

/* dv/uest_tb_if.sv */
// Testbench package: expected-result record for one transaction.
`timescale 1ns / 1ps
package uest_tb_pkg;
  // expected result of one transaction
  typedef struct packed {
    logic [63:0] ulp_distance;
    logic [22:0] bits_error;
    logic        is_new_max;
    logic        start_tracking;
    logic [22:0] max_error_now;
    logic [47:0] total_error_now;
    logic [31:0] call_count_now;
  } ulp_stat_t;
endpackage

/* dv/tb.sv */
// Testbench: directed table then random traffic, checked against a built-in predictor.
`timescale 1ns / 1ps
module tb;
  import uest_pkg::*;
  import uest_tb_pkg::*;

  // one row of the directed table; has_exp marks rows whose result is typed in
  typedef struct {
    logic [63:0] ref_b;
    logic [63:0] cmp_b;
    logic [7:0]  op;
    bit          has_exp;
    logic [63:0] exp_ulps;
    logic [22:0] exp_bits;
  } row_t;

  localparam logic [63:0] PosZero = 64'h0;
  localparam logic [63:0] NegZero = 64'h8000_0000_0000_0000;
  localparam logic [63:0] QNan    = 64'h7FF8_0000_0000_0000;
  localparam logic [63:0] NegNan  = 64'hFFF0_0000_0000_0001;
  localparam logic [63:0] PosInf  = 64'h7FF0_0000_0000_0000;
  localparam logic [63:0] NegInf  = 64'hFFF0_0000_0000_0000;
  localparam logic [63:0] OneD    = 64'h3FF0_0000_0000_0000;
  localparam logic [22:0] BitsMax = 23'h40_0000;   // 64.0, only from 2^64-1
  localparam logic [22:0] Bits63  = 23'h3F_0000;   // 63.0, one-NaN case

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #5 clk_i = ~clk_i;

  uest_in_if  in_ch();
  uest_out_if out_ch();
  uest_cfg_if cfg_ch();

  ulp_error_statistics_table uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source),
    .cfg_i (cfg_ch.sink)
  );

  // predictor state
  logic [BitsW-1:0] thresh_q;
  logic [BitsW-1:0] max_tab [NumOps];
  logic [TotW-1:0]  tot_tab [NumOps];
  logic [CntW-1:0]  cnt_tab [NumOps];

  ulp_stat_t pending_q[$];
  int        fail_cnt = 0;
  int        src_idle = 0;   // percent
  int        snk_idle = 0;

  function automatic logic [63:0] order_key(logic [63:0] b);
    return b[63] ? Sign64 - {1'b0, b[62:0]} : Sign64 + {1'b0, b[62:0]};
  endfunction

  function automatic logic [63:0] ulp_gap(logic [63:0] a, logic [63:0] b);
    logic na, nb;
    logic [63:0] ka, kb;
    na = a[62:0] > InfMag;
    nb = b[62:0] > InfMag;
    if (na && nb) return 64'd0;
    if (na || nb) return Sign64;
    ka = order_key(a);
    kb = order_key(b);
    return ka >= kb ? ka - kb : kb - ka;
  endfunction

  // log2(n) by repeated squaring, rounded to nearest
  function automatic logic [BitsW-1:0] log2_q(logic [63:0] n);
    int e;
    logic [63:0]  m;
    logic [127:0] sq;
    logic [31:0]  acc;
    e = 0;
    acc = 0;
    for (int i = 63; i >= 0; i--) if (n[i]) begin
      e = i;
      break;
    end
    m = n << (63 - e);
    for (int i = 0; i < FracSteps; i++) begin
      sq = m * m;
      if (sq[127]) begin
        acc = (acc << 1) | 1;
        m = sq[127:64];
      end else begin
        acc = acc << 1;
        m = sq[126:63];
      end
    end
    acc = (32'(e) << FracSteps) | acc;
    return BitsW'((acc + 1) >> 1);
  endfunction

  function automatic ulp_stat_t predict_stats(logic [63:0] a, logic [63:0] b, logic [7:0] op);
    ulp_stat_t r;
    logic [48:0] sum;
    r.ulp_distance = ulp_gap(a, b);
    r.bits_error = log2_q(r.ulp_distance + 64'd1);
    r.is_new_max = 0;
    r.start_tracking = 0;
    if (r.bits_error > max_tab[op]) begin
      r.is_new_max = 1;
      r.start_tracking = (max_tab[op] < thresh_q) && (r.bits_error > thresh_q);
      max_tab[op] = r.bits_error;
    end
    sum = {1'b0, tot_tab[op]} + 49'(r.bits_error);
    tot_tab[op] = sum[48] ? '1 : sum[47:0];
    if (cnt_tab[op] != '1) cnt_tab[op] = cnt_tab[op] + 1;
    r.max_error_now = max_tab[op];
    r.total_error_now = tot_tab[op];
    r.call_count_now = cnt_tab[op];
    return r;
  endfunction

  // sends one transaction at the falling edge, waits for acceptance;
  // valid stays up until the next transaction or an explicit drop
  task automatic send_pair(logic [63:0] a, logic [63:0] b, logic [7:0] op);
    while ($urandom_range(99) < src_idle) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.reference_bits <= a;
    in_ch.computed_bits <= b;
    in_ch.op_index <= op;
    pending_q.push_back(predict_stats(a, b, op));
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // writes the threshold once the block has drained
  task automatic write_thresh(logic [BitsW-1:0] v);
    in_ch.valid <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);   // covers the longest latency
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= v;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    thresh_q = v;
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  // random doubles: specials (NaN, infinities, signed zeros) or random bit patterns
  function automatic logic [63:0] rand_double();
    case ($urandom_range(9))
      0: return QNan | 64'($urandom);
      1: return $urandom_range(1) ? PosInf : NegInf;
      2: return $urandom_range(1) ? PosZero : NegZero;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic random_phase(int count);
    logic [63:0] a, b, d;
    for (int i = 0; i < count; i++) begin
      a = rand_double();
      d = {$urandom, $urandom} >> $urandom_range(63);
      case ($urandom_range(3))
        0: b = rand_double();
        1: b = a + d;
        2: b = a - d;
        default: b = a ^ (64'd1 << $urandom_range(63));
      endcase
      send_pair(a, b, 8'($urandom_range(7) == 0 ? $urandom : $urandom_range(15)));
    end
  endtask

  // sink: random stalls, checks against the oldest expectation
  always @(negedge clk_i) out_ch.ready <= ($urandom_range(99) >= snk_idle);

  always @(posedge clk_i) begin
    ulp_stat_t e;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_q.size() == 0) begin
        $error("result with no expectation");
        fail_cnt++;
      end else begin
        e = pending_q.pop_front();
        if (out_ch.ulp_distance !== e.ulp_distance) begin
          $error("ulp_distance exp %h got %h", e.ulp_distance, out_ch.ulp_distance);
          fail_cnt++;
        end
        if (out_ch.bits_error !== e.bits_error) begin
          $error("bits_error exp %h got %h", e.bits_error, out_ch.bits_error);
          fail_cnt++;
        end
        if (out_ch.is_new_max !== e.is_new_max) begin
          $error("is_new_max exp %b got %b", e.is_new_max, out_ch.is_new_max);
          fail_cnt++;
        end
        if (out_ch.start_tracking !== e.start_tracking) begin
          $error("start_tracking exp %b got %b", e.start_tracking, out_ch.start_tracking);
          fail_cnt++;
        end
        if (out_ch.max_error_now !== e.max_error_now) begin
          $error("max_error_now exp %h got %h", e.max_error_now, out_ch.max_error_now);
          fail_cnt++;
        end
        if (out_ch.total_error_now !== e.total_error_now) begin
          $error("total_error_now exp %h got %h", e.total_error_now, out_ch.total_error_now);
          fail_cnt++;
        end
        if (out_ch.call_count_now !== e.call_count_now) begin
          $error("call_count_now exp %h got %h", e.call_count_now, out_ch.call_count_now);
          fail_cnt++;
        end
      end
    end
  end

  row_t dir_rows[$];

  initial begin
    ulp_stat_t p;
    in_ch.valid = 0;
    in_ch.reference_bits = 0;
    in_ch.computed_bits = 0;
    in_ch.op_index = 0;
    cfg_ch.valid = 0;
    cfg_ch.data = 0;
    out_ch.ready = 0;
    thresh_q = ThreshReset;
    for (int i = 0; i < NumOps; i++) begin
      max_tab[i] = 0;
      tot_tab[i] = 0;
      cnt_tab[i] = 0;
    end
    // signed zeros, NaN payloads, infinities, extremes, index extremes
    dir_rows = '{
      '{PosZero, NegZero, 8'd0,   1, 64'd0, 23'd0},
      '{NegZero, PosZero, 8'd255, 1, 64'd0, 23'd0},
      '{QNan,    NegNan,  8'd1,   1, 64'd0, 23'd0},
      '{QNan,    OneD,    8'd1,   1, Sign64, Bits63},
      '{OneD,    NegNan,  8'd2,   1, Sign64, Bits63},
      '{OneD,    OneD + 1, 8'd3,  1, 64'd1, 23'h1_0000},
      '{PosInf,  NegInf,  8'd4,   0, 64'd0, 23'd0},
      '{64'h7FEF_FFFF_FFFF_FFFF, 64'hFFEF_FFFF_FFFF_FFFF, 8'd5, 0, 64'd0, 23'd0},
      '{64'hFFFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF, 8'd6, 1, 64'd0, 23'd0},
      '{64'h0000_0000_0000_0001, 64'h8000_0000_0000_0001, 8'd7, 1, 64'd2, 23'h1_95C0},
      '{OneD,    OneD,    8'd128, 1, 64'd0, 23'd0},
      '{64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 8'd170, 0, 64'd0, 23'd0},
      '{PosZero, 64'h0000_0000_0000_00FF, 8'd85, 1, 64'd255, 23'h8_0000}
    };
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed walk, receiver always ready
    foreach (dir_rows[i]) begin
      send_pair(dir_rows[i].ref_b, dir_rows[i].cmp_b, dir_rows[i].op);
      p = pending_q[$];
      if (dir_rows[i].has_exp && (p.ulp_distance !== dir_rows[i].exp_ulps ||
          p.bits_error !== dir_rows[i].exp_bits)) begin
        $error("table row %0d: ulp_distance/bits_error exp %h/%h predicted %h/%h", i,
               dir_rows[i].exp_ulps, dir_rows[i].exp_bits, p.ulp_distance, p.bits_error);
        fail_cnt++;
      end
    end

    // threshold extremes, then middle values
    src_idle = 14;
    snk_idle = 50;
    write_thresh('0);
    random_phase(150);
    write_thresh(BitsMax);
    random_phase(150);
    write_thresh(23'h7F_FFFF);
    random_phase(100);
    write_thresh(23'h14_0000);
    random_phase(250);
    src_idle = 50;
    snk_idle = 14;
    write_thresh(23'h0A_0000);
    random_phase(250);
    src_idle = 0;
    snk_idle = 0;
    write_thresh(ThreshReset);
    random_phase(200);

    in_ch.valid <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
    if (fail_cnt == 0)
      $display("ulp_error_statistics_table test passed");
    else
      $display("ulp_error_statistics_table test failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("ulp_error_statistics_table test failed");
    $finish;
  end
endmodule
